// File: design/srec_pkg.sv
// Shared package for the segment / rectangle edge crossing unit.
// Holds coordinate types, lane and sideband records and register codes; no dependencies.
package srec_pkg;

	localparam int COORD_BITS = 31;
	localparam int LANES      = 4;

	// lane order: top, bottom, left, right edge
	localparam int L_TOP   = 0;
	localparam int L_BOT   = 1;
	localparam int L_LEFT  = 2;
	localparam int L_RIGHT = 3;

	typedef logic [COORD_BITS-1:0]   coord_t;
	typedef logic [2*COORD_BITS-1:0] prod_t;

	typedef enum logic [1:0] {
		REG_LEFT   = 2'd0,
		REG_RIGHT  = 2'd1,
		REG_TOP    = 2'd2,
		REG_BOTTOM = 2'd3
	} reg_idx_t;

	typedef struct packed {
		coord_t left;
		coord_t right;
		coord_t top;
		coord_t bottom;
	} rect_t;

	// per-edge interpolation job
	typedef struct packed {
		logic   cin;   // entering test fires
		logic   cout;  // leaving test fires
		logic   neg;   // other coordinate decreases along the segment
		coord_t a0;    // other coordinate at the previous point
		coord_t den;   // |denominator|
	} lane_t;

	typedef struct packed {
		logic   on_edge;
		coord_t px;
		coord_t py;
	} side_t;

	function automatic coord_t absdiff(input coord_t a, input coord_t b);
		return (a >= b) ? coord_t'(a - b) : coord_t'(b - a);
	endfunction

endpackage

// File: design/srec_prep.sv
// Front stages: straddle tests and magnitudes (stage 1), products (stage 2).
// Depends on srec_pkg.
module srec_prep
	import srec_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   adv,
	input  logic   in_valid,
	input  coord_t cur_x,
	input  coord_t cur_y,
	input  coord_t prev_x,
	input  coord_t prev_y,
	input  rect_t  rect,
	output logic   v_s2,
	output lane_t  lane_s2 [LANES],
	output prod_t  num_s2 [LANES],
	output side_t  side_s2
);

	lane_t  lane_c [LANES];
	coord_t d_c [LANES];
	coord_t s_c [LANES];
	side_t  side_c;

	logic   v_s1;
	lane_t  lane_s1 [LANES];
	coord_t d_s1 [LANES];
	coord_t s_s1 [LANES];
	side_t  side_s1;

	always_comb begin
		lane_c[L_TOP].cin  = (prev_y < rect.top) && (cur_y >= rect.top);
		lane_c[L_TOP].cout = (prev_y > rect.top) && (cur_y <= rect.top);
		lane_c[L_TOP].neg  = cur_x < prev_x;
		lane_c[L_TOP].a0   = prev_x;
		lane_c[L_TOP].den  = absdiff(cur_y, prev_y);
		d_c[L_TOP]         = absdiff(cur_x, prev_x);
		s_c[L_TOP]         = absdiff(rect.top, prev_y);

		lane_c[L_BOT].cin  = (prev_y > rect.bottom) && (cur_y <= rect.bottom);
		lane_c[L_BOT].cout = (prev_y < rect.bottom) && (cur_y >= rect.bottom);
		lane_c[L_BOT].neg  = cur_x < prev_x;
		lane_c[L_BOT].a0   = prev_x;
		lane_c[L_BOT].den  = absdiff(cur_y, prev_y);
		d_c[L_BOT]         = absdiff(cur_x, prev_x);
		s_c[L_BOT]         = absdiff(rect.bottom, prev_y);

		lane_c[L_LEFT].cin  = (prev_x < rect.left) && (cur_x >= rect.left);
		lane_c[L_LEFT].cout = (prev_x > rect.left) && (cur_x <= rect.left);
		lane_c[L_LEFT].neg  = cur_y < prev_y;
		lane_c[L_LEFT].a0   = prev_y;
		lane_c[L_LEFT].den  = absdiff(cur_x, prev_x);
		d_c[L_LEFT]         = absdiff(cur_y, prev_y);
		s_c[L_LEFT]         = absdiff(rect.left, prev_x);

		lane_c[L_RIGHT].cin  = (prev_x > rect.right) && (cur_x <= rect.right);
		lane_c[L_RIGHT].cout = (prev_x < rect.right) && (cur_x >= rect.right);
		lane_c[L_RIGHT].neg  = cur_y < prev_y;
		lane_c[L_RIGHT].a0   = prev_y;
		lane_c[L_RIGHT].den  = absdiff(cur_x, prev_x);
		d_c[L_RIGHT]         = absdiff(cur_y, prev_y);
		s_c[L_RIGHT]         = absdiff(rect.right, prev_x);

		side_c.on_edge = (prev_x == rect.right) || (prev_x == rect.left)
			|| (prev_y == rect.top) || (prev_y == rect.bottom);
		side_c.px = prev_x;
		side_c.py = prev_y;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			lane_s1 <= lane_c;
			d_s1    <= d_c;
			s_s1    <= s_c;
			side_s1 <= side_c;
			lane_s2 <= lane_s1;
			side_s2 <= side_s1;
			for (int i = 0; i < LANES; i++) begin
				num_s2[i] <= prod_t'(d_s1[i]) * prod_t'(s_s1[i]);
			end
		end
	end

endmodule

// File: design/srec_div.sv
// Pipelined restoring divider, one quotient bit per stage, four lanes side by side.
// Depends on srec_pkg.
module srec_div
	import srec_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   adv,
	input  logic   v_in,
	input  lane_t  lane_in [LANES],
	input  prod_t  num_in [LANES],
	input  side_t  side_in,
	output logic   v_out,
	output lane_t  lane_out [LANES],
	output coord_t q_out [LANES],
	output logic   rnz_out [LANES],
	output side_t  side_out
);

	logic [COORD_BITS-1:0] v_s;
	coord_t rem_s [COORD_BITS][LANES];
	coord_t sh_s [COORD_BITS][LANES];
	lane_t  lane_s [COORD_BITS][LANES];
	side_t  side_s [COORD_BITS];

	coord_t rem_src [COORD_BITS][LANES];
	coord_t sh_src [COORD_BITS][LANES];
	lane_t  lane_src [COORD_BITS][LANES];
	coord_t rem_nx [COORD_BITS][LANES];
	coord_t sh_nx [COORD_BITS][LANES];

	for (genvar k = 0; k < COORD_BITS; k++) begin : g_st
		for (genvar i = 0; i < LANES; i++) begin : g_ln
			logic [COORD_BITS:0] trial;
			logic ge;
			if (k == 0) begin : g_first
				assign rem_src[k][i]  = num_in[i][2*COORD_BITS-1:COORD_BITS];
				assign sh_src[k][i]   = num_in[i][COORD_BITS-1:0];
				assign lane_src[k][i] = lane_in[i];
			end else begin : g_next
				assign rem_src[k][i]  = rem_s[k-1][i];
				assign sh_src[k][i]   = sh_s[k-1][i];
				assign lane_src[k][i] = lane_s[k-1][i];
			end
			assign trial = {rem_src[k][i], sh_src[k][i][COORD_BITS-1]};
			assign ge    = trial >= {1'b0, lane_src[k][i].den};
			assign rem_nx[k][i] = ge ? coord_t'(trial - {1'b0, lane_src[k][i].den})
				: trial[COORD_BITS-1:0];
			assign sh_nx[k][i]  = {sh_src[k][i][COORD_BITS-2:0], ge};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (adv) begin
				v_s[k] <= (k == 0) ? v_in : v_s[(k == 0) ? 0 : k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[k]  <= rem_nx[k];
				sh_s[k]   <= sh_nx[k];
				lane_s[k] <= lane_src[k];
				side_s[k] <= (k == 0) ? side_in : side_s[(k == 0) ? 0 : k-1];
			end
		end
	end

	assign v_out    = v_s[COORD_BITS-1];
	assign lane_out = lane_s[COORD_BITS-1];
	assign q_out    = sh_s[COORD_BITS-1];
	assign side_out = side_s[COORD_BITS-1];
	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			rnz_out[i] = rem_s[COORD_BITS-1][i] != '0;
		end
	end

	// a held pipeline keeps every occupied slot
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(v_s))
		else $error("divider valid bits moved while held");

	// advancing shifts occupancy by one stage
	a_shift: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> v_s[COORD_BITS-1:1] == $past(v_s[COORD_BITS-2:0]))
		else $error("divider valid bits lost or repeated");

endmodule

// File: design/srec_pick.sv
// Back stages: rounding and offset (stage 34), range checks, priority pick and
// output register (stage 35). Depends on srec_pkg.
module srec_pick
	import srec_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   adv,
	input  rect_t  rect,
	input  logic   v_in,
	input  lane_t  lane_in [LANES],
	input  coord_t q_in [LANES],
	input  logic   rnz_in [LANES],
	input  side_t  side_in,
	output logic   v_s35,
	output logic   found_s35,
	output coord_t x_s35,
	output coord_t y_s35
);

	coord_t t_c [LANES];
	logic   v_s34;
	coord_t t_s34 [LANES];
	logic   cin_s34 [LANES];
	logic   cout_s34 [LANES];
	side_t  side_s34;

	logic   ok [LANES];
	logic   hit [2*LANES];
	coord_t hx [LANES];
	coord_t hy [LANES];
	logic   found_c;
	coord_t x_c;
	coord_t y_c;

	// floor when increasing, ceil when decreasing: truncation of a nonnegative value
	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			logic [COORD_BITS:0] mag;
			mag = {1'b0, q_in[i]} + {{COORD_BITS{1'b0}}, lane_in[i].neg & rnz_in[i]};
			t_c[i] = lane_in[i].neg ? coord_t'({1'b0, lane_in[i].a0} - mag)
				: coord_t'({1'b0, lane_in[i].a0} + mag);
		end
	end

	always_comb begin
		ok[L_TOP]   = (rect.left <= t_s34[L_TOP]) && (t_s34[L_TOP] <= rect.right);
		ok[L_BOT]   = (rect.left <= t_s34[L_BOT]) && (t_s34[L_BOT] <= rect.right);
		ok[L_LEFT]  = (rect.top <= t_s34[L_LEFT]) && (t_s34[L_LEFT] <= rect.bottom);
		ok[L_RIGHT] = (rect.top <= t_s34[L_RIGHT]) && (t_s34[L_RIGHT] <= rect.bottom);
		hx[L_TOP]   = t_s34[L_TOP];
		hy[L_TOP]   = rect.top;
		hx[L_BOT]   = t_s34[L_BOT];
		hy[L_BOT]   = rect.bottom;
		hx[L_LEFT]  = rect.left;
		hy[L_LEFT]  = t_s34[L_LEFT];
		hx[L_RIGHT] = rect.right;
		hy[L_RIGHT] = t_s34[L_RIGHT];
		for (int i = 0; i < LANES; i++) begin
			hit[i]         = cin_s34[i] & ok[i];
			hit[i + LANES] = cout_s34[i] & ok[i];
		end
		found_c = 1'b0;
		x_c = side_s34.on_edge ? side_s34.px : '0;
		y_c = side_s34.on_edge ? side_s34.py : '0;
		// entering tests win over leaving ones, lanes in edge order
		for (int j = 2*LANES-1; j >= 0; j--) begin
			if (hit[j]) begin
				found_c = 1'b1;
				x_c = hx[j % LANES];
				y_c = hy[j % LANES];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s34 <= 1'b0;
			v_s35 <= 1'b0;
		end else if (adv) begin
			v_s34 <= v_in;
			v_s35 <= v_s34;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			t_s34    <= t_c;
			side_s34 <= side_in;
			for (int i = 0; i < LANES; i++) begin
				cin_s34[i]  <= lane_in[i].cin;
				cout_s34[i] <= lane_in[i].cout;
			end
			found_s35 <= found_c;
			x_s35     <= x_c;
			y_s35     <= y_c;
		end
	end

endmodule

// File: design/segment_rectangle_edge_crossing_unit.sv
// Top level of the segment / rectangle edge crossing unit: config registers,
// flow control and the three pipeline parts. Depends on srec_pkg, srec_prep, srec_div, srec_pick.

// Each item is a segment from (prev_x, prev_y) to (cur_x, cur_y); the unit returns one
// result item per input item, in order: the first crossing with the clip rectangle's
// edges (entering tests top, bottom, left, right, then leaving tests in the same order),
// with found set, or, without a crossing, the previous point if it lies on an edge line
// and zeros otherwise. The interpolated coordinate is exact and truncated toward zero.
// The unit takes one item per clock while in_stall is low; the divider resolves one
// quotient bit per stage over 31 stages, with two front and two back stages.
// The whole pipe advances together: in_stall is high exactly while a result sits on the
// output and out_stall holds it. Write the rectangle registers only while the unit is
// empty; they are read live by the stages.
module segment_rectangle_edge_crossing_unit
	import srec_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cfg_we,
	input  reg_idx_t cfg_index,
	input  coord_t   cfg_data,
	input  logic     in_valid,
	output logic     in_stall,
	input  coord_t   cur_x,
	input  coord_t   cur_y,
	input  coord_t   prev_x,
	input  coord_t   prev_y,
	output logic     out_valid,
	input  logic     out_stall,
	output logic     found,
	output coord_t   cross_x,
	output coord_t   cross_y
);

	rect_t  rect_q;
	logic   adv;

	logic   v_s2;
	lane_t  lane_s2 [LANES];
	prod_t  num_s2 [LANES];
	side_t  side_s2;

	logic   v_dv;
	lane_t  lane_dv [LANES];
	coord_t q_dv [LANES];
	logic   rnz_dv [LANES];
	side_t  side_dv;

	// rectangle registers; reset covers the whole coordinate space
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rect_q.left   <= '0;
			rect_q.right  <= '1;
			rect_q.top    <= '0;
			rect_q.bottom <= '1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LEFT:   rect_q.left   <= cfg_data;
				REG_RIGHT:  rect_q.right  <= cfg_data;
				REG_TOP:    rect_q.top    <= cfg_data;
				REG_BOTTOM: rect_q.bottom <= cfg_data;
				default:    rect_q        <= rect_q;
			endcase
		end
	end

	// output register free or being drained: everything moves
	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;

	srec_prep u_prep (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (in_valid),
		.cur_x    (cur_x),
		.cur_y    (cur_y),
		.prev_x   (prev_x),
		.prev_y   (prev_y),
		.rect     (rect_q),
		.v_s2     (v_s2),
		.lane_s2  (lane_s2),
		.num_s2   (num_s2),
		.side_s2  (side_s2)
	);

	srec_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.v_in     (v_s2),
		.lane_in  (lane_s2),
		.num_in   (num_s2),
		.side_in  (side_s2),
		.v_out    (v_dv),
		.lane_out (lane_dv),
		.q_out    (q_dv),
		.rnz_out  (rnz_dv),
		.side_out (side_dv)
	);

	srec_pick u_pick (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.rect      (rect_q),
		.v_in      (v_dv),
		.lane_in   (lane_dv),
		.q_in      (q_dv),
		.rnz_in    (rnz_dv),
		.side_in   (side_dv),
		.v_s35     (out_valid),
		.found_s35 (found),
		.x_s35     (cross_x),
		.y_s35     (cross_y)
	);

	// a crossing always lies on one of the edge lines
	a_found_on_edge: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found |-> (cross_x == rect_q.left) || (cross_x == rect_q.right)
			|| (cross_y == rect_q.top) || (cross_y == rect_q.bottom))
		else $error("crossing off every edge line");

	// no crossing: either zeros or a point on an edge line
	a_miss_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> (cross_x == '0 && cross_y == '0)
			|| (cross_x == rect_q.left) || (cross_x == rect_q.right)
			|| (cross_y == rect_q.top) || (cross_y == rect_q.bottom))
		else $error("miss result neither zero nor on edge");

	// a held result stays put until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable({found, cross_x, cross_y}))
		else $error("held result changed");

endmodule

// File: verif/tb_top.sv
// Testbench for segment_rectangle_edge_crossing_unit: directed and random segments
// against several clip rectangles, each result checked against an in-bench predictor.
// Depends on srec_pkg and the unit's RTL.
`timescale 1ns / 1ps

module tb_top;
	import srec_pkg::*;

	localparam int MAX_CYCLES = 400000;
	localparam int DRAIN_CYCLES = 45;

	typedef struct {
		logic   found;
		coord_t x;
		coord_t y;
	} crossing_t;

	logic   clk;
	logic   arst_n;
	logic   cfg_we;
	reg_idx_t cfg_index;
	coord_t cfg_data;
	logic   in_valid;
	logic   in_stall;
	coord_t cur_x, cur_y, prev_x, prev_y;
	logic   out_valid;
	logic   out_stall = 1'b0;
	logic   found;
	coord_t cross_x, cross_y;

	// predictor copy of the rectangle registers
	longint rect_l, rect_r, rect_tp, rect_b;

	crossing_t expected_q[$];
	int  err_count;
	int  cycle_count = 0;
	bit  stall_enable;

	segment_rectangle_edge_crossing_unit uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.cur_x(cur_x), .cur_y(cur_y), .prev_x(prev_x), .prev_y(prev_y),
		.out_valid(out_valid), .out_stall(out_stall),
		.found(found), .cross_x(cross_x), .cross_y(cross_y)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > MAX_CYCLES) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic report_mismatch(input string what);
		$display("mismatch at cycle %0d: %s", cycle_count, what);
		err_count++;
	endtask

	// a0 + (a1-a0)*span/den, truncated toward zero; no division when den is zero
	function automatic longint lerp_trunc(input longint a0, input longint a1,
			input longint span, input longint den);
		longint num, q, r, base;
		if (den == 0)
			return a0;
		num = (a1 - a0) * span;
		if (den < 0) begin
			num = -num;
			den = -den;
		end
		q = num / den;
		r = num % den;
		base = a0 + q;
		if (r < 0 && base > 0)
			base -= 1;
		else if (r > 0 && base < 0)
			base += 1;
		return base;
	endfunction

	function automatic crossing_t predict_crossing(input coord_t cx, input coord_t cy,
			input coord_t px_in, input coord_t py_in);
		crossing_t res;
		longint x, y, px, py, t, ox, oy;
		bit hit, entering, c_top, c_bot, c_left, c_right;
		x = cx; y = cy; px = px_in; py = py_in;
		ox = 0; oy = 0; hit = 0;
		// entering tests first, then leaving tests; order top, bottom, left, right
		for (int pass = 0; pass < 2 && !hit; pass++) begin
			entering = (pass == 0);
			c_top   = entering ? (py < rect_tp && y >= rect_tp)
				: (py > rect_tp && y <= rect_tp);
			c_bot   = entering ? (py > rect_b && y <= rect_b) : (py < rect_b && y >= rect_b);
			c_left  = entering ? (px < rect_l && x >= rect_l) : (px > rect_l && x <= rect_l);
			c_right = entering ? (px > rect_r && x <= rect_r) : (px < rect_r && x >= rect_r);
			if (!hit && c_top) begin
				t = lerp_trunc(px, x, rect_tp - py, y - py);
				if (rect_l <= t && t <= rect_r) begin
					hit = 1; ox = t; oy = rect_tp;
				end
			end
			if (!hit && c_bot) begin
				t = lerp_trunc(px, x, py - rect_b, py - y);
				if (rect_l <= t && t <= rect_r) begin
					hit = 1; ox = t; oy = rect_b;
				end
			end
			if (!hit && c_left) begin
				t = lerp_trunc(py, y, rect_l - px, x - px);
				if (t >= rect_tp && t <= rect_b) begin
					hit = 1; ox = rect_l; oy = t;
				end
			end
			if (!hit && c_right) begin
				t = lerp_trunc(py, y, px - rect_r, px - x);
				if (t >= rect_tp && t <= rect_b) begin
					hit = 1; ox = rect_r; oy = t;
				end
			end
		end
		// no crossing: previous point on an edge line is passed through
		if (!hit && (px == rect_r || px == rect_l || py == rect_tp || py == rect_b)) begin
			ox = px;
			oy = py;
		end
		res.found = hit;
		res.x = coord_t'(ox);
		res.y = coord_t'(oy);
		return res;
	endfunction

	// result checker plus random output stall
	int stall_wait = 0;
	always @(posedge clk) begin
		crossing_t exp_res;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_q.size() == 0) begin
				report_mismatch("result with nothing expected");
			end else begin
				exp_res = expected_q.pop_front();
				if (found !== exp_res.found)
					report_mismatch($sformatf("found %b, expected %b", found, exp_res.found));
				if (cross_x !== exp_res.x)
					report_mismatch($sformatf("cross_x %0d, expected %0d", cross_x, exp_res.x));
				if (cross_y !== exp_res.y)
					report_mismatch($sformatf("cross_y %0d, expected %0d", cross_y, exp_res.y));
			end
			stall_wait = stall_enable ? $urandom_range(0, 3) : 0;
		end else if (stall_wait > 0) begin
			stall_wait--;
		end
		out_stall <= (stall_wait > 0);
	end

	// item send with an optional random gap ahead of it; valid stays up after the accept
	// so that items can follow back to back
	task automatic send_segment(input coord_t cx, input coord_t cy,
			input coord_t px, input coord_t py, input bit use_gaps = 1);
		int gap;
		gap = use_gaps ? $urandom_range(0, 3) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cur_x <= cx;
		cur_y <= cy;
		prev_x <= px;
		prev_y <= py;
		expected_q.insert(expected_q.size(), predict_crossing(cx, cy, px, py));
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// write enable stays up across consecutive writes; set_rect drops it
	task automatic write_reg(input reg_idx_t idx, input coord_t value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		case (idx)
			REG_LEFT:   rect_l = value;
			REG_RIGHT:  rect_r = value;
			REG_TOP:    rect_tp = value;
			REG_BOTTOM: rect_b = value;
			default:    ;
		endcase
	endtask

	task automatic set_rect(input coord_t l, input coord_t r, input coord_t t, input coord_t b);
		wait_idle();
		write_reg(REG_LEFT, l);
		write_reg(REG_RIGHT, r);
		write_reg(REG_TOP, t);
		write_reg(REG_BOTTOM, b);
		cfg_we <= 1'b0;
	endtask

	function automatic coord_t rand_coord();
		return coord_t'($urandom);
	endfunction

	// coordinate near edge value e0 or e1, or anywhere
	function automatic coord_t near_edge(input longint e0, input longint e1);
		longint v;
		case ($urandom_range(0, 4))
			0: v = e0 + $signed($urandom_range(0, 6)) - 3;
			1: v = e1 + $signed($urandom_range(0, 6)) - 3;
			2: v = e0 + $urandom_range(0, 2000) - 1000;
			3: v = e1 + $urandom_range(0, 2000) - 1000;
			default: return rand_coord();
		endcase
		if (v < 0) v = 0;
		if (v > 64'h7fffffff) v = 64'h7fffffff;
		return coord_t'(v);
	endfunction

	task automatic test_extremes();
		coord_t mx;
		mx = '1;
		set_rect(0, mx, 0, mx);
		send_segment(0, 0, 0, 0);
		send_segment(mx, mx, mx, mx);
		send_segment(mx, 0, 0, mx);
		send_segment(5, 5, 7, 9);
		set_rect(100, 200, 100, 200);
		// entering through each edge
		send_segment(150, 150, 150, 50);    // top
		send_segment(150, 150, 150, 300);   // bottom
		send_segment(150, 150, 50, 150);    // left
		send_segment(150, 150, 300, 150);   // right
		// leaving through each edge
		send_segment(150, 50, 150, 150);
		send_segment(150, 300, 150, 150);
		send_segment(50, 150, 150, 150);
		send_segment(300, 150, 150, 150);
		// diagonal, truncation of negative slope
		send_segment(0, 301, 301, 0);
		send_segment(mx, mx, 0, 0);
		// no crossing, previous point on edge lines
		send_segment(150, 150, 100, 150);
		send_segment(150, 150, 150, 200);
		// no crossing, entirely outside
		send_segment(10, 10, 20, 20);
		// crossing line outside the edge extent
		send_segment(500, 150, 500, 50);
	endtask

	task automatic test_inverted_rect();
		set_rect(300, 100, 400, 200);
		send_segment(200, 300, 50, 50);
		send_segment(50, 50, 200, 300);
		send_segment(300, 250, 100, 400);
		send_segment(0, 0, 300, 200);
	endtask

	task automatic random_phase(input int n, input coord_t l, input coord_t r,
			input coord_t t, input coord_t b);
		coord_t a, c, p, q;
		set_rect(l, r, t, b);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 9) < 8) begin
				a = near_edge(l, r); c = near_edge(t, b);
				p = near_edge(l, r); q = near_edge(t, b);
			end else begin
				a = rand_coord(); c = rand_coord();
				p = rand_coord(); q = rand_coord();
			end
			send_segment(a, c, p, q);
		end
	endtask

	task automatic test_random_rects();
		coord_t mx, l, r, t, b;
		mx = '1;
		random_phase(300, 0, mx, 0, mx);
		random_phase(300, 1000, 5000, 2000, 9000);
		random_phase(250, 0, 0, mx, mx);
		for (int k = 0; k < 4; k++) begin
			l = rand_coord(); r = rand_coord(); t = rand_coord(); b = rand_coord();
			if (k < 3) begin
				if (l > r) {l, r} = {r, l};
				if (t > b) {t, b} = {b, t};
			end
			random_phase(250, l, r, t, b);
		end
	endtask

	// back-to-back items with the receiver never stalling
	task automatic test_full_rate();
		wait_idle();
		stall_enable = 0;
		for (int i = 0; i < 60; i++)
			send_segment(near_edge(rect_l, rect_r), near_edge(rect_tp, rect_b),
				near_edge(rect_l, rect_r), near_edge(rect_tp, rect_b), 0);
		stall_enable = 1;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_LEFT;
		cfg_data = '0;
		in_valid = 1'b0;
		cur_x = '0; cur_y = '0; prev_x = '0; prev_y = '0;
		stall_enable = 1;
		err_count = 0;
		rect_l = 0; rect_r = 64'h7fffffff; rect_tp = 0; rect_b = 64'h7fffffff;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_extremes();
		test_inverted_rect();
		test_random_rects();
		test_full_rate();

		wait_idle();
		if (err_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
